FILE: sv/jsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants for the JSON string unescaper
// Phase codes, result kinds, the decoder state and the result bundle that
// travels from the decoder to the output stage.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int LEN_BITS = 16;
    localparam int CAP_BITS = 16;
    localparam int CMP_W    = ((LEN_BITS > CAP_BITS) ? LEN_BITS : CAP_BITS) + 1;
    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(256);

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_BODY = 4'd1,
        PH_ESC  = 4'd2,
        PH_HEX0 = 4'd3,
        PH_HEX1 = 4'd4,
        PH_HEX2 = 4'd5,
        PH_HEX3 = 4'd6,
        PH_SBS  = 4'd7,
        PH_SU   = 4'd8,
        PH_LOW0 = 4'd9,
        PH_LOW1 = 4'd10,
        PH_LOW2 = 4'd11,
        PH_LOW3 = 4'd12
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef struct packed {
        t_phase              phase;
        logic [15:0]         hex;
        logic [9:0]          hi;
        logic [LEN_BITS-1:0] used;
    } t_state;

    // Results caused by one input item: num beats (0..4) of the same kind.
    typedef struct packed {
        t_kind           kind;
        logic [2:0]      num;
        logic [3:0][7:0] bytes;
        logic [15:0]     length;
    } t_bundle;

endpackage

FILE: sv/jsu_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_decode: per-byte unescape step
// Combinational next-state and result bundle for one input item: escape
// decoding, hex accumulation, surrogate joining, UTF-8 encoding and the
// capacity check.
// ----------------------------------------------------------------------------
module jsu_decode (
    input  jsu_pkg::t_state              i_state,
    input  logic                         i_start_req,
    input  logic [7:0]                   i_data_byte,
    input  logic                         i_region_end,
    input  logic [jsu_pkg::CAP_BITS-1:0] i_out_capacity,
    output jsu_pkg::t_state              o_state,
    output jsu_pkg::t_bundle             o_bundle
);

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [jsu_pkg::CMP_W-1:0] CAP_LIM =
        jsu_pkg::CMP_W'(1) << jsu_pkg::LEN_BITS;

    logic [3:0]                  hex_d;
    logic                        hex_ok;
    logic [15:0]                 hex_n;
    logic [20:0]                 cp;
    logic [2:0]                  cp_n;
    logic [3:0][7:0]             cp_b;
    logic                        req_emit;
    logic [2:0]                  req_n;
    logic [3:0][7:0]             req_b;
    logic                        set_err;
    logic [jsu_pkg::CMP_W-1:0]   cap_eff;

    // hex digit value
    always_comb begin
        hex_ok = 1'b1;
        hex_d  = 4'd0;
        if (i_data_byte >= 8'h30 && i_data_byte <= 8'h39) begin
            hex_d = i_data_byte[3:0];
        end else if ((i_data_byte >= 8'h61 && i_data_byte <= 8'h66) ||
                     (i_data_byte >= 8'h41 && i_data_byte <= 8'h46)) begin
            hex_d = i_data_byte[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign hex_n = {i_state.hex[11:0], hex_d};

    // join surrogates on the low half, else the plain 16-bit value
    assign cp = (i_state.phase == jsu_pkg::PH_LOW3)
              ? 21'h10000 + {1'b0, i_state.hi, 10'b0} + {11'b0, hex_n[9:0]}
              : {5'b0, hex_n};

    always_comb begin
        cp_b = '0;
        if (cp <= 21'h7f) begin
            cp_n    = 3'd1;
            cp_b[0] = cp[7:0];
        end else if (cp <= 21'h7ff) begin
            cp_n    = 3'd2;
            cp_b[0] = {3'b110, cp[10:6]};
            cp_b[1] = {2'b10, cp[5:0]};
        end else if (cp <= 21'hffff) begin
            cp_n    = 3'd3;
            cp_b[0] = {4'b1110, cp[15:12]};
            cp_b[1] = {2'b10, cp[11:6]};
            cp_b[2] = {2'b10, cp[5:0]};
        end else begin
            cp_n    = 3'd4;
            cp_b[0] = {5'b11110, cp[20:18]};
            cp_b[1] = {2'b10, cp[17:12]};
            cp_b[2] = {2'b10, cp[11:6]};
            cp_b[3] = {2'b10, cp[5:0]};
        end
    end

    assign cap_eff = (jsu_pkg::CMP_W'(i_out_capacity) > CAP_LIM)
                   ? CAP_LIM : jsu_pkg::CMP_W'(i_out_capacity);

    always_comb begin
        o_state         = i_state;
        o_bundle.kind   = jsu_pkg::KIND_DATA;
        o_bundle.num    = 3'd0;
        o_bundle.bytes  = '0;
        o_bundle.length = '0;
        req_emit        = 1'b0;
        req_n           = 3'd1;
        req_b           = '0;
        set_err         = 1'b0;

        if (i_start_req) begin
            if (i_region_end || i_data_byte != CH_QUOTE || i_out_capacity == '0) begin
                set_err = 1'b1;
            end else begin
                o_state.phase = jsu_pkg::PH_BODY;
                o_state.used  = '0;
                o_state.hex   = '0;
                o_state.hi    = '0;
            end
        end else if (i_state.phase == jsu_pkg::PH_IDLE) begin
            o_state = i_state;
        end else if (i_region_end || i_data_byte == 8'h00) begin
            set_err = 1'b1;
        end else begin
            case (i_state.phase)
                jsu_pkg::PH_BODY: begin
                    if (i_data_byte == CH_QUOTE) begin
                        o_state.phase   = jsu_pkg::PH_IDLE;
                        o_bundle.kind   = jsu_pkg::KIND_DONE;
                        o_bundle.num    = 3'd1;
                        o_bundle.length = 16'(i_state.used);
                    end else if (i_data_byte == CH_BSLASH) begin
                        o_state.phase = jsu_pkg::PH_ESC;
                    end else if (i_data_byte < CH_SPACE) begin
                        set_err = 1'b1;
                    end else begin
                        req_emit = 1'b1;
                        req_b[0] = i_data_byte;
                    end
                end
                jsu_pkg::PH_ESC: begin
                    o_state.phase = jsu_pkg::PH_BODY;
                    req_emit      = 1'b1;
                    case (i_data_byte)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: req_b[0] = i_data_byte;
                        CH_B: req_b[0] = 8'h08;
                        CH_F: req_b[0] = 8'h0c;
                        CH_N: req_b[0] = 8'h0a;
                        CH_R: req_b[0] = 8'h0d;
                        CH_T: req_b[0] = 8'h09;
                        CH_U: begin
                            req_emit      = 1'b0;
                            o_state.phase = jsu_pkg::PH_HEX0;
                            o_state.hex   = '0;
                        end
                        default: begin
                            req_emit = 1'b0;
                            set_err  = 1'b1;
                        end
                    endcase
                end
                jsu_pkg::PH_SBS: begin
                    if (i_data_byte != CH_BSLASH) begin
                        set_err = 1'b1;
                    end else begin
                        o_state.phase = jsu_pkg::PH_SU;
                    end
                end
                jsu_pkg::PH_SU: begin
                    if (i_data_byte != CH_U) begin
                        set_err = 1'b1;
                    end else begin
                        o_state.phase = jsu_pkg::PH_LOW0;
                        o_state.hex   = '0;
                    end
                end
                jsu_pkg::PH_HEX0, jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2,
                jsu_pkg::PH_LOW0, jsu_pkg::PH_LOW1, jsu_pkg::PH_LOW2: begin
                    if (!hex_ok) begin
                        set_err = 1'b1;
                    end else begin
                        o_state.hex   = hex_n;
                        o_state.phase = jsu_pkg::t_phase'(i_state.phase + 4'd1);
                    end
                end
                jsu_pkg::PH_HEX3: begin
                    if (!hex_ok) begin
                        set_err = 1'b1;
                    end else begin
                        o_state.hex = hex_n;
                        if (hex_n >= 16'hd800 && hex_n <= 16'hdbff) begin
                            // high surrogate: wait for the escaped low half
                            o_state.hi    = hex_n[9:0];
                            o_state.phase = jsu_pkg::PH_SBS;
                        end else if (hex_n == 16'h0000 ||
                                     (hex_n >= 16'hdc00 && hex_n <= 16'hdfff)) begin
                            set_err = 1'b1;
                        end else begin
                            o_state.phase = jsu_pkg::PH_BODY;
                            req_emit      = 1'b1;
                            req_n         = cp_n;
                            req_b         = cp_b;
                        end
                    end
                end
                jsu_pkg::PH_LOW3: begin
                    if (!hex_ok || hex_n < 16'hdc00 || hex_n > 16'hdfff) begin
                        set_err = 1'b1;
                    end else begin
                        o_state.hex   = hex_n;
                        o_state.phase = jsu_pkg::PH_BODY;
                        req_emit      = 1'b1;
                        req_n         = cp_n;
                        req_b         = cp_b;
                    end
                end
                default: begin
                    o_state.phase = jsu_pkg::PH_IDLE;
                end
            endcase
        end

        if (req_emit) begin
            if (jsu_pkg::CMP_W'(i_state.used) + jsu_pkg::CMP_W'(req_n) >= cap_eff) begin
                set_err = 1'b1;
            end else begin
                o_bundle.num   = req_n;
                o_bundle.bytes = req_b;
                o_state.used   = i_state.used + jsu_pkg::LEN_BITS'(req_n);
            end
        end

        if (set_err) begin
            o_state.phase   = jsu_pkg::PH_IDLE;
            o_bundle.kind   = jsu_pkg::KIND_ERR;
            o_bundle.num    = 3'd1;
            o_bundle.bytes  = '0;
            o_bundle.length = '0;
        end
    end

endmodule

FILE: sv/json_string_unescape_utf8_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top: JSON string unescaper with UTF-8 output
// Takes a quoted JSON string one byte per beat and returns decoded UTF-8
// bytes, then a completion beat with the length, or an error beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries start_req, data_byte and
//   region_end. Each beat lands in an input register; it is decoded from
//   there and its results (0 to 4 beats) load the result register once free.
//   Output channel (o_out_valid / i_out_ready) drains one result per cycle
//   while i_out_ready is high; o_last marks the final result of the input
//   beat that caused it.
//   Throughput: one input beat per cycle while each beat yields at most one
//   result and the receiver is ready; an escape that decodes to N UTF-8 bytes
//   holds the input side while the result register drains them one per cycle.
//   When the receiver stalls, the result register holds and the input
//   register takes one more beat before o_in_ready drops.
//   Reset clears both registers, the decoder to idle and out_capacity to
//   256. Write out_capacity (i_cfg_wr_en) only while the block is idle.
//   After an error, downstream discards the bytes already delivered.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [jsu_pkg::CAP_BITS-1:0] i_cfg_wr_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_start_req,
    input  logic [7:0]                   i_data_byte,
    input  logic                         i_region_end,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [1:0]                   o_result_kind,
    output logic [7:0]                   o_out_byte,
    output logic [15:0]                  o_length,
    output logic                         o_last
);

    logic [jsu_pkg::CAP_BITS-1:0] r_out_capacity;
    logic                         r_in_valid;
    logic                         r_in_start;
    logic [7:0]                   r_in_byte;
    logic                         r_in_end;
    jsu_pkg::t_state              r_state;
    jsu_pkg::t_state              n_state;
    jsu_pkg::t_bundle             r_bnd;
    jsu_pkg::t_bundle             n_bnd;
    logic [2:0]                   r_num;
    logic [1:0]                   r_pos;

    logic last_beat;
    logic bnd_free;
    logic step;

    jsu_decode u_decode (
        .i_state        (r_state),
        .i_start_req    (r_in_start),
        .i_data_byte    (r_in_byte),
        .i_region_end   (r_in_end),
        .i_out_capacity (r_out_capacity),
        .o_state        (n_state),
        .o_bundle       (n_bnd)
    );

    assign o_out_valid = (r_num != 3'd0);
    assign last_beat   = ({1'b0, r_pos} == (r_num - 3'd1));
    assign bnd_free    = !o_out_valid || (last_beat && i_out_ready);
    assign step        = r_in_valid && bnd_free;
    assign o_in_ready  = !r_in_valid || bnd_free;

    assign o_result_kind = r_bnd.kind;
    assign o_out_byte    = (r_bnd.kind == jsu_pkg::KIND_DATA) ? r_bnd.bytes[r_pos] : 8'h00;
    assign o_length      = r_bnd.length;
    assign o_last        = last_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_capacity <= jsu_pkg::CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_out_capacity <= i_cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_start <= i_start_req;
            r_in_byte  <= i_data_byte;
            r_in_end   <= i_region_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase <= jsu_pkg::PH_IDLE;
            r_state.hex   <= '0;
            r_state.hi    <= '0;
            r_state.used  <= '0;
        end else if (step) begin
            r_state <= n_state;
        end
    end

    // result register: load a new bundle or advance through the current one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= 3'd0;
            r_pos <= 2'd0;
        end else if (step && n_bnd.num != 3'd0) begin
            r_num <= n_bnd.num;
            r_pos <= 2'd0;
        end else if (o_out_valid && i_out_ready) begin
            if (last_beat) begin
                r_num <= 3'd0;
                r_pos <= 2'd0;
            end else begin
                r_pos <= r_pos + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && n_bnd.num != 3'd0) begin
            r_bnd <= n_bnd;
        end
    end

`ifndef SYNTHESIS
    a_single_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind != jsu_pkg::KIND_DATA) |-> o_last)
        else $error("done or error result not marked last");

    a_err_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && n_bnd.num != 3'd0 && n_bnd.kind == jsu_pkg::KIND_ERR)
        |=> (r_state.phase == jsu_pkg::PH_IDLE))
        else $error("decoder not idle after error");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_num <= 3'd4 && {1'b0, r_pos} < r_num))
        else $error("result position out of range");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !(last_beat && i_out_ready)) |=> o_out_valid)
        else $error("result bundle dropped before drained");
`endif

endmodule

FILE: tb/sv/tb_json_string_unescape_utf8_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_string_unescape_utf8_top: self-checking bench for the JSON unescaper
// Feeds quoted strings byte by byte: a short directed set of escapes and
// faults, a receiver hold-off that fills the block, drained pauses and random
// strings over several buffer capacities. A local decoder predicts every
// result beat, and each delivered beat is compared field by field.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_utf8_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 6;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] ESC_CHARS [8] =
        '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};

    typedef struct {
        logic       st;
        logic [7:0] c;
        logic       re;
    } t_item;

    typedef struct {
        jsu_pkg::t_kind kind;
        logic [7:0]     ob;
        logic [15:0]    len;
        logic           is_last;
    } t_result;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_wr_en;
    logic [jsu_pkg::CAP_BITS-1:0] cfg_wr_data;
    logic                         in_valid;
    logic                         in_ready;
    logic                         start_req;
    logic [7:0]                   data_byte;
    logic                         region_end;
    logic                         out_valid;
    logic                         out_ready;
    logic [1:0]                   result_kind;
    logic [7:0]                   out_byte;
    logic [15:0]                  length;
    logic                         res_last;

    // decoder copy
    jsu_pkg::t_phase dec_phase;
    logic [15:0]     dec_hex;
    logic [9:0]      dec_hi;
    logic [15:0]     dec_used;
    logic [15:0]     dec_cap;

    t_result beat_results[$];
    t_result pending_results[$];
    t_item   str_q[$];

    int fails;
    int idle_cycles;
    int hold_req;
    int hold_left;
    int gap_left;
    bit tx_gaps;
    bit rx_stalls;

    json_string_unescape_utf8_top i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_start_req   (start_req),
        .i_data_byte   (data_byte),
        .i_region_end  (region_end),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_result_kind (result_kind),
        .o_out_byte    (out_byte),
        .o_length      (length),
        .o_last        (res_last)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int nibble_of(logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    // ------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------
    function automatic void add_result(jsu_pkg::t_kind k, logic [7:0] b, logic [15:0] len);
        t_result r;
        r.kind    = k;
        r.ob      = b;
        r.len     = len;
        r.is_last = 1'b0;
        beat_results.push_back(r);
    endfunction

    function automatic void decode_error();
        dec_phase = jsu_pkg::PH_IDLE;
        beat_results.delete();
        add_result(jsu_pkg::KIND_ERR, 8'h00, 16'h0000);
    endfunction

    // Drop the whole code point when it would reach the capacity.
    function automatic void emit_utf8(logic [3:0][7:0] b, int n);
        if ({1'b0, dec_used} + 17'(n) >= {1'b0, dec_cap}) begin
            decode_error();
            return;
        end
        for (int i = 0; i < n; i++) add_result(jsu_pkg::KIND_DATA, b[i], 16'h0000);
        dec_used = dec_used + 16'(n);
    endfunction

    function automatic void emit_code_point(logic [20:0] cp);
        logic [3:0][7:0] b;
        int n;
        b = '0;
        if (cp == 0 || cp > 21'h10ffff || (cp >= 21'hd800 && cp <= 21'hdfff)) begin
            decode_error();
            return;
        end
        if (cp <= 21'h7f) begin
            b[0] = cp[7:0];
            n = 1;
        end else if (cp <= 21'h7ff) begin
            b[0] = 8'hc0 | cp[10:6];
            b[1] = 8'h80 | cp[5:0];
            n = 2;
        end else if (cp <= 21'hffff) begin
            b[0] = 8'he0 | cp[15:12];
            b[1] = 8'h80 | cp[11:6];
            b[2] = 8'h80 | cp[5:0];
            n = 3;
        end else begin
            b[0] = 8'hf0 | cp[20:18];
            b[1] = 8'h80 | cp[17:12];
            b[2] = 8'h80 | cp[11:6];
            b[3] = 8'h80 | cp[5:0];
            n = 4;
        end
        dec_phase = jsu_pkg::PH_BODY;
        emit_utf8(b, n);
    endfunction

    function automatic void decode_beat(logic st, logic [7:0] c, logic re);
        int d;
        logic [7:0] lit;
        beat_results.delete();
        lit = 8'h00;
        if (st) begin
            if (re || c != CH_QUOTE || dec_cap == 0) begin
                decode_error();
            end else begin
                dec_phase = jsu_pkg::PH_BODY;
                dec_used  = '0;
                dec_hex   = '0;
                dec_hi    = '0;
            end
        end else if (dec_phase == jsu_pkg::PH_IDLE) begin
            // ignored
        end else if (re || c == 8'h00) begin
            decode_error();
        end else begin
            case (dec_phase)
                jsu_pkg::PH_BODY: begin
                    if (c == CH_QUOTE) begin
                        dec_phase = jsu_pkg::PH_IDLE;
                        add_result(jsu_pkg::KIND_DONE, 8'h00, dec_used);
                    end else if (c == CH_BSLASH) begin
                        dec_phase = jsu_pkg::PH_ESC;
                    end else if (c < 8'h20) begin
                        decode_error();
                    end else begin
                        emit_utf8(32'(c), 1);
                    end
                end
                jsu_pkg::PH_ESC: begin
                    case (c)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: lit = c;
                        CH_B: lit = 8'h08;
                        CH_F: lit = 8'h0c;
                        CH_N: lit = 8'h0a;
                        CH_R: lit = 8'h0d;
                        CH_T: lit = 8'h09;
                        default: lit = 8'h00;
                    endcase
                    if (c == CH_U) begin
                        dec_phase = jsu_pkg::PH_HEX0;
                        dec_hex   = '0;
                    end else if (lit == 8'h00) begin
                        decode_error();
                    end else begin
                        dec_phase = jsu_pkg::PH_BODY;
                        emit_utf8(32'(lit), 1);
                    end
                end
                jsu_pkg::PH_SBS: begin
                    if (c != CH_BSLASH) decode_error();
                    else dec_phase = jsu_pkg::PH_SU;
                end
                jsu_pkg::PH_SU: begin
                    if (c != CH_U) begin
                        decode_error();
                    end else begin
                        dec_phase = jsu_pkg::PH_LOW0;
                        dec_hex   = '0;
                    end
                end
                jsu_pkg::PH_HEX0, jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3: begin
                    d = nibble_of(c);
                    if (d < 0) begin
                        decode_error();
                    end else begin
                        dec_hex = {dec_hex[11:0], 4'(d)};
                        if (dec_phase != jsu_pkg::PH_HEX3) begin
                            dec_phase = jsu_pkg::t_phase'(dec_phase + 4'd1);
                        end else if (dec_hex >= 16'hd800 && dec_hex <= 16'hdbff) begin
                            dec_hi    = dec_hex[9:0];
                            dec_phase = jsu_pkg::PH_SBS;
                        end else begin
                            emit_code_point(21'(dec_hex));
                        end
                    end
                end
                jsu_pkg::PH_LOW0, jsu_pkg::PH_LOW1, jsu_pkg::PH_LOW2, jsu_pkg::PH_LOW3: begin
                    d = nibble_of(c);
                    if (d < 0) begin
                        decode_error();
                    end else begin
                        dec_hex = {dec_hex[11:0], 4'(d)};
                        if (dec_phase != jsu_pkg::PH_LOW3) begin
                            dec_phase = jsu_pkg::t_phase'(dec_phase + 4'd1);
                        end else if (dec_hex < 16'hdc00 || dec_hex > 16'hdfff) begin
                            decode_error();
                        end else begin
                            // low 10 bits of the low half are its offset from 0xdc00
                            emit_code_point(21'h10000 + {1'b0, dec_hi, dec_hex[9:0]});
                        end
                    end
                end
                default: dec_phase = jsu_pkg::PH_IDLE;
            endcase
        end
        if (beat_results.size() > 0) beat_results[beat_results.size() - 1].is_last = 1'b1;
        foreach (beat_results[i]) pending_results.push_back(beat_results[i]);
    endfunction

    // ------------------------------------------------------------------
    // String building
    // ------------------------------------------------------------------
    function automatic logic [7:0] hex_char(logic [3:0] v);
        logic [7:0] base;
        if (v < 4'd10) return "0" + 8'(v);
        base = $urandom_range(0, 1) ? "A" : "a";
        return base + 8'(v) - 8'd10;
    endfunction

    function automatic bit is_escape_char(logic [7:0] c);
        if (c == CH_U) return 1'b1;
        foreach (ESC_CHARS[i]) if (c == ESC_CHARS[i]) return 1'b1;
        return 1'b0;
    endfunction

    function automatic void add_item(logic st, logic [7:0] c, logic re);
        t_item it;
        it.st = st;
        it.c  = c;
        it.re = re;
        str_q.push_back(it);
    endfunction

    function automatic void add_byte(logic [7:0] c);
        add_item(1'b0, c, 1'b0);
    endfunction

    function automatic void add_u_escape(logic [15:0] v);
        add_byte(CH_BSLASH);
        add_byte(CH_U);
        for (int i = 3; i >= 0; i--) add_byte(hex_char(v[i*4 +: 4]));
    endfunction

    function automatic void add_token();
        int roll;
        int k;
        logic [15:0] v;
        logic [7:0] c;
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
            c = 8'($urandom_range(8'h20, 8'h7e));
            if (c == CH_QUOTE || c == CH_BSLASH) c = 8'h20;
            add_byte(c);
        end else if (roll < 40) begin
            add_byte(8'($urandom_range(8'h80, 8'hff)));
        end else if (roll < 55) begin
            add_byte(CH_BSLASH);
            add_byte(ESC_CHARS[3'($urandom_range(0, 7))]);
        end else if (roll < 70) begin
            case ($urandom_range(0, 2))
                0: v = 16'($urandom_range(16'h0001, 16'h007f));
                1: v = 16'($urandom_range(16'h0080, 16'h07ff));
                default: v = 16'($urandom_range(16'h0800, 16'hffff));
            endcase
            if (v >= 16'hd800 && v <= 16'hdfff) v ^= 16'h4000;
            add_u_escape(v);
        end else if (roll < 80) begin
            add_u_escape(16'hd800 + 16'($urandom_range(0, 16'h3ff)));
            add_u_escape(16'hdc00 + 16'($urandom_range(0, 16'h3ff)));
        end else if (roll < 84) begin
            add_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
        end else if (roll < 87) begin
            add_byte(8'($urandom_range(8'h01, 8'h1f)));
        end else if (roll < 89) begin
            add_byte(8'h00);
        end else if (roll < 91) begin
            do c = 8'($urandom_range(1, 255)); while (is_escape_char(c));
            add_byte(CH_BSLASH);
            add_byte(c);
        end else if (roll < 93) begin
            add_byte(CH_BSLASH);
            add_byte(CH_U);
            k = $urandom_range(0, 3);
            repeat (k) add_byte(hex_char(4'($urandom_range(0, 15))));
            do c = 8'($urandom_range(1, 255)); while (nibble_of(c) >= 0);
            add_byte(c);
        end else if (roll < 95) begin
            add_u_escape(16'h0000);
        end else if (roll < 97) begin
            add_u_escape(16'hdc00 + 16'($urandom_range(0, 16'h3ff)));
        end else if (roll < 99) begin
            // high surrogate without a proper low half
            add_u_escape(16'hd800 + 16'($urandom_range(0, 16'h3ff)));
            case ($urandom_range(0, 2))
                0: add_byte("A");
                1: begin
                    add_byte(CH_BSLASH);
                    add_byte(ESC_CHARS[3'($urandom_range(0, 7))]);
                end
                default: begin
                    v = 16'($urandom_range(0, 16'hffff));
                    if (v >= 16'hdc00 && v <= 16'hdfff) v ^= 16'h0400;
                    add_u_escape(v);
                end
            endcase
        end else begin
            add_item(1'b1, CH_QUOTE, 1'b0);
        end
    endfunction

    function automatic void build_string(int n_tokens, bit close);
        add_item(1'b1, CH_QUOTE, 1'b0);
        repeat (n_tokens) add_token();
        if (close) add_byte(CH_QUOTE);
    endfunction

    function automatic int pick_len();
        if ($urandom_range(0, 99) < 80) return $urandom_range(0, 6);
        return $urandom_range(7, 14);
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    task automatic send_item(input t_item it);
        int gap;
        gap = (tx_gaps && $urandom_range(0, 99) < 25) ? pick_gap() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        start_req  <= it.st;
        data_byte  <= it.c;
        region_end <= it.re;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        decode_beat(it.st, it.c, it.re);
    endtask

    task automatic send_queued();
        t_item it;
        while (str_q.size() > 0) begin
            it = str_q.pop_front();
            send_item(it);
        end
    endtask

    task automatic wait_idle(input int settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [15:0] value);
        wait_idle(SETTLE_CYCLES);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        dec_cap = value;
        cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver, checker, watchdog
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (hold_req > 0) begin
            hold_left = hold_req - 1;
            hold_req  = 0;
            out_ready <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left--;
            out_ready <= 1'b0;
        end else if (rx_stalls && $urandom_range(0, 99) < 20) begin
            gap_left = pick_gap() - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin : check_result
        t_result want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                fails++;
                $display("%0t: unexpected beat: expected none, got kind %0d byte %02h len %0d last %0d",
                         $time, result_kind, out_byte, length, res_last);
            end else begin
                want = pending_results.pop_front();
                if (result_kind !== want.kind || out_byte !== want.ob ||
                    length !== want.len || res_last !== want.is_last) begin
                    fails++;
                    $display("%0t: mismatch: expected kind %0d byte %02h len %0d last %0d, %s %0d %02h %0d %0d",
                             $time, want.kind, want.ob, want.len, want.is_last,
                             "got kind/byte/len/last", result_kind, out_byte, length, res_last);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog: no beat for %0d cycles", $time, idle_cycles);
            $display("** json_string_unescape_utf8_top: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        // raw high byte, 4-byte code point from a surrogate pair, close
        add_item(1'b1, CH_QUOTE, 1'b0);
        add_byte(8'hff);
        add_byte(CH_BSLASH); add_byte(CH_U);
        add_byte("D"); add_byte("8"); add_byte("3"); add_byte("D");
        add_byte(CH_BSLASH); add_byte(CH_U);
        add_byte("d"); add_byte("e"); add_byte("0"); add_byte("0");
        add_byte(CH_QUOTE);
        // start faults and an ignored idle byte
        add_item(1'b1, CH_QUOTE, 1'b1);
        add_item(1'b0, "A", 1'b0);
        add_item(1'b1, "x", 1'b0);
        // restart mid-escape, then a bad escape
        add_item(1'b1, CH_QUOTE, 1'b0);
        add_byte(CH_BSLASH);
        add_item(1'b1, CH_QUOTE, 1'b0);
        add_byte(CH_BSLASH); add_byte("q");
        // raw control byte, then NUL
        add_item(1'b1, CH_QUOTE, 1'b0);
        add_byte(8'h1f);
        add_item(1'b1, CH_QUOTE, 1'b0);
        add_byte(8'h00);
        send_queued();
    endtask

    task automatic test_backpressure();
        wait_idle(SETTLE_CYCLES);
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        hold_req  = HOLD_CYCLES;
        add_item(1'b1, CH_QUOTE, 1'b0);
        repeat (20) add_byte(8'($urandom_range(8'h23, 8'h5b)));
        add_u_escape(16'h20ac);
        add_byte(CH_QUOTE);
        send_queued();
    endtask

    task automatic test_drain_pause();
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
        repeat (4) begin
            build_string(pick_len(), 1'b1);
            send_queued();
            // hold the sender until every result is back
            wait_idle(0);
        end
    endtask

    task automatic test_random_settings();
        logic [15:0] caps [8] = '{16'd256, 16'd5, 16'd1, 16'd0,
                                  16'd65535, 16'd12, 16'd4, 16'd40};
        int budgets [8] = '{40, 35, 12, 10, 40, 35, 35, 35};
        int sent;
        for (int p = 0; p < 8; p++) begin
            cfg_write(caps[p]);
            tx_gaps   = (p != 0) && (p % 3 != 1);
            rx_stalls = (p != 0) && (p % 3 != 2);
            sent = 0;
            while (sent < budgets[p]) begin
                if ($urandom_range(0, 99) < 10)
                    add_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
                build_string(pick_len(), $urandom_range(0, 99) < 85);
                sent += str_q.size();
                send_queued();
            end
        end
    endtask

    initial begin
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        in_valid    <= 1'b0;
        start_req   <= 1'b0;
        data_byte   <= 8'h00;
        region_end  <= 1'b0;
        out_ready   <= 1'b0;
        fails       = 0;
        idle_cycles = 0;
        hold_req    = 0;
        hold_left   = 0;
        gap_left    = 0;
        tx_gaps     = 1'b0;
        rx_stalls   = 1'b0;
        dec_phase   = jsu_pkg::PH_IDLE;
        dec_hex     = '0;
        dec_hi      = '0;
        dec_used    = '0;
        dec_cap     = jsu_pkg::CAP_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_drain_pause();
        test_random_settings();

        wait_idle(SETTLE_CYCLES + 2);
        if (fails == 0 && pending_results.size() == 0) begin
            $display("** json_string_unescape_utf8_top: PASSED **");
        end else begin
            $display("** json_string_unescape_utf8_top: FAILED **");
        end
        $finish;
    end

endmodule
